@@ src/readout_word_hit_pairing_unpacker_core_assert.svh @@
// Assertion macros for the readout word unpacker.
// Included by the datapath, which checks its own logic; needs clk and rst in scope.
`ifndef READOUT_WORD_HIT_PAIRING_UNPACKER_CORE_ASSERT_SVH
`define READOUT_WORD_HIT_PAIRING_UNPACKER_CORE_ASSERT_SVH

`ifndef SYNTH
`define RWHPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RWHPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RWHPU_ASSERT_IMP(lbl, ante, cons, msg)
`define RWHPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/rwhpu_pkg.sv @@
// Shared types and constants of the readout word unpacker.
// No dependencies.
package rwhpu_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CW      = 6;
  localparam int COL_W       = 3;
  localparam int TB_W        = 48;
  localparam int AMP_W       = 13;
  localparam int TL_W        = 7;
  localparam int CH_W        = 4;
  localparam int CHIP_W      = 6;
  localparam int PAD_W       = 9;
  localparam int OFF_W       = 4;
  localparam logic [TB_W-1:0] EPOCH_STEP = 48'd128;

  typedef struct packed {
    logic [31:0]     word;
    logic [TB_W-1:0] base_time;
    logic            slice_start;
    logic            slice_end;
  } in_item_t;

  typedef struct packed {
    logic [PAD_W-1:0]        pad_address;
    logic [AMP_W-1:0]        charge_t;
    logic [AMP_W-1:0]        charge_r;
    logic [TB_W-1:0]         hit_time;
    logic signed [OFF_W-1:0] time_offset;
    logic                    dropped;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [TL_W-1:0]  tl;
    logic [CH_W-1:0]  ch;
  } msg_t;

  typedef struct packed {
    logic [TL_W-1:0]         tlab;
    logic [AMP_W-1:0]        cht;
    logic [AMP_W-1:0]        chr;
    logic signed [OFF_W-1:0] off;
  } hit_t;

  typedef struct packed {
    logic             load_word;
    logic             ss_apply;
    logic             epoch_apply;
    logic             data_apply;
    logic             se_apply;
    logic             flush_end;
    logic             pm_rd;
    logic             hl_rd;
    logic             hl_new;
    logic             hl_merge;
    logic             push;
    logic             fin;
    logic [COL_W-1:0] col;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ss;
    logic se;
    logic aux;
    logic ch_zero;
    logic grp_change;
    logic pend_nz;
    logic msg_in_col;
    logic hit_match;
    logic push_stall;
    logic fin_stall;
  } dp_status_t;

endpackage

@@ src/rwhpu_in_if.sv @@
// Input channel of the readout word unpacker: valid/ready with one word item.
// Depends on rwhpu_pkg.
interface rwhpu_in_if;
  logic                valid;
  logic                ready;
  rwhpu_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ src/rwhpu_out_if.sv @@
// Output channel of the readout word unpacker: valid/ready with one hit item.
// Depends on rwhpu_pkg.
interface rwhpu_out_if;
  logic                 valid;
  logic                 ready;
  rwhpu_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ src/rwhpu_datapath.sv @@
// Datapath: group state, message buffer, hit list, hold and output registers.
// Depends on rwhpu_pkg and the assertion macro header.
`include "readout_word_hit_pairing_unpacker_core_assert.svh"
module rwhpu_datapath #(
  parameter int NUM_COLUMNS   = 8,
  parameter int PENDING_DEPTH = 32,
  parameter int AW            = $clog2(PENDING_DEPTH),
  parameter int CW            = $clog2(PENDING_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rwhpu_pkg::in_item_t  in_data,
  input  rwhpu_pkg::ctrl_cmd_t cmd,
  input  logic [AW-1:0]        pm_raddr,
  input  logic [AW-1:0]        hl_addr,
  output rwhpu_pkg::dp_status_t st,
  output logic [CW-1:0]        pcnt,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rwhpu_pkg::out_item_t out_data
);
  import rwhpu_pkg::*;

  in_item_t word_q;
  msg_t     pm [PENDING_DEPTH];
  msg_t     pm_q;
  hit_t     hl [PENDING_DEPTH];
  hit_t     hl_q;

  logic [CHIP_W-1:0] gchip;
  logic              gopen;
  logic              gdrop;
  logic [TB_W-1:0]   tb;

  out_item_t       hold;
  logic            hold_v;
  logic [RES_CW-1:0] cnt;
  logic            ovf;

  out_item_t         out_data_next;
  out_item_t         hold_next;
  logic              hold_v_next;
  logic              out_valid_next;
  logic [RES_CW-1:0] cnt_next;
  logic              ovf_next;

  // decoded input word
  logic [CH_W-1:0]   w_ch;
  logic              w_aux;
  logic [TL_W-1:0]   w_tl;
  logic [AMP_W-1:0]  w_amp;
  logic [CHIP_W-1:0] w_chip;
  logic              w_col_ok;
  logic              grp_change;

  assign w_ch       = word_q.word[3:0];
  assign w_aux      = word_q.word[4];
  assign w_tl       = word_q.word[11:5];
  assign w_amp      = word_q.word[25:13];
  assign w_chip     = word_q.word[31:26];
  assign w_col_ok   = {1'b0, w_ch[3:1]} < 4'(NUM_COLUMNS);
  assign grp_change = !gopen || (gchip != w_chip);

  // pairing of the current message against the hit read back
  logic               m_odd;
  logic               m_has;
  logic signed [7:0]  d;
  logic signed [7:0]  d_neg;
  logic               d_near;
  logic               match;
  hit_t               merged;
  hit_t               fresh;

  assign m_odd  = pm_q.ch[0];
  assign m_has  = pm_q.amp != '0;
  assign d      = signed'({1'b0, hl_q.tlab}) - signed'({1'b0, pm_q.tl});
  assign d_neg  = -d;
  assign d_near = (d > -8'sd5) && (d < 8'sd5);
  assign match  = d_near && m_has &&
                  ((m_odd && hl_q.chr == '0) || (!m_odd && hl_q.cht == '0));

  always_comb begin
    merged = hl_q;
    if (m_odd) begin
      merged.chr = pm_q.amp;
      merged.off = d_neg[OFF_W-1:0];
    end else begin
      merged.cht = pm_q.amp;
      merged.off = d[OFF_W-1:0];
    end
    fresh.tlab = pm_q.tl;
    fresh.cht  = m_odd ? '0 : pm_q.amp;
    fresh.chr  = m_odd ? pm_q.amp : '0;
    fresh.off  = '0;
  end

  // hit formatting
  logic [11:0] pad_full;
  out_item_t   hit_item;
  assign pad_full = 12'(gchip) * 12'(NUM_COLUMNS) + 12'(cmd.col);

  always_comb begin
    hit_item.pad_address = pad_full[PAD_W-1:0];
    hit_item.charge_t    = hl_q.cht;
    hit_item.charge_r    = hl_q.chr;
    hit_item.hit_time    = tb + TB_W'(hl_q.tlab);
    hit_item.time_offset = hl_q.off;
    hit_item.dropped     = gdrop;
    hit_item.last        = 1'b0;
  end

  logic slot_busy;
  logic push_stall;
  logic fin_stall;
  logic at_max;
  logic push_go;
  logic fin_go;

  assign slot_busy  = out_valid && !out_ready;
  assign at_max     = cnt == RES_CW'(MAX_RESULTS);
  assign push_stall = !at_max && hold_v && slot_busy;
  assign fin_stall  = hold_v && slot_busy;
  assign push_go    = cmd.push && !push_stall;
  assign fin_go     = cmd.fin && !fin_stall;

  always_comb begin
    st.ss         = word_q.slice_start;
    st.se         = word_q.slice_end;
    st.aux        = w_aux;
    st.ch_zero    = w_ch == '0;
    st.grp_change = grp_change;
    st.pend_nz    = pcnt != '0;
    st.msg_in_col = pm_q.ch[3:1] == cmd.col;
    st.hit_match  = match;
    st.push_stall = push_stall;
    st.fin_stall  = fin_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) word_q <= in_data;
    if (cmd.pm_rd) pm_q <= pm[pm_raddr];
    if (cmd.hl_rd) hl_q <= hl[hl_addr];
    if (cmd.hl_new) hl[hl_addr] <= fresh;
    else if (cmd.hl_merge) hl[hl_addr] <= merged;
    if (cmd.data_apply && w_col_ok && pcnt < CW'(PENDING_DEPTH)) begin
      pm[pcnt[AW-1:0]] <= '{amp: w_amp, tl: w_tl, ch: w_ch};
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt  <= '0;
      gchip <= '0;
      gopen <= 1'b0;
      gdrop <= 1'b0;
      tb    <= '0;
    end else begin
      if (cmd.ss_apply) begin
        gopen <= 1'b0;
        tb    <= word_q.base_time;
      end
      if (cmd.epoch_apply) begin
        gopen <= 1'b0;
        if (w_chip == '0) tb <= tb + EPOCH_STEP;
      end
      if (cmd.data_apply) begin
        if (grp_change) begin
          gchip <= w_chip;
          gopen <= 1'b1;
          gdrop <= 1'b0;
        end
        if (w_col_ok) begin
          if (pcnt < CW'(PENDING_DEPTH)) pcnt <= pcnt + 1'b1;
          else gdrop <= 1'b1;
        end
      end
      if (cmd.se_apply) begin
        gopen <= 1'b0;
        gdrop <= 1'b0;
      end
      if (cmd.flush_end) begin
        pcnt  <= '0;
        gopen <= 1'b0;
        gdrop <= 1'b0;
      end
    end
  end

  // one hit is held back so the final one of a word can be marked
  always_comb begin
    out_data_next  = out_data;
    out_valid_next = out_valid && !out_ready;
    hold_next      = hold;
    hold_v_next    = hold_v;
    cnt_next       = cnt;
    ovf_next       = ovf;
    if (push_go) begin
      if (at_max) begin
        ovf_next = 1'b1;
      end else begin
        if (hold_v) begin
          out_data_next  = hold;
          out_valid_next = 1'b1;
        end
        hold_next   = hit_item;
        hold_v_next = 1'b1;
        cnt_next    = cnt + 1'b1;
      end
    end
    if (fin_go) begin
      if (hold_v) begin
        out_data_next         = hold;
        out_data_next.last    = 1'b1;
        out_data_next.dropped = hold.dropped | ovf;
        out_valid_next        = 1'b1;
      end
      hold_v_next = 1'b0;
      cnt_next    = '0;
      ovf_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    hold     <= hold_next;
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      ovf       <= 1'b0;
    end else begin
      hold_v    <= hold_v_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
    end
  end

  `RWHPU_ASSERT_IMP(a_pcnt_bound, 1'b1, pcnt <= CW'(PENDING_DEPTH), "buffer count past depth")
  `RWHPU_ASSERT_IMP(a_ovf_full, ovf, at_max, "overflow flagged below hit limit")
  `RWHPU_ASSERT_IMP(a_hold_counted, hold_v, cnt != '0, "held hit not counted")
  `RWHPU_ASSERT_NEXT(a_fin_clears, fin_go, !hold_v && cnt == '0, "word end left a hit held")

endmodule

@@ src/rwhpu_ctrl.sv @@
// Controller: word phases and the flush sequencer with its column/message/hit counters.
// Depends on rwhpu_pkg.
module rwhpu_ctrl #(
  parameter int NUM_COLUMNS   = 8,
  parameter int PENDING_DEPTH = 32,
  parameter int AW            = $clog2(PENDING_DEPTH),
  parameter int CW            = $clog2(PENDING_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rwhpu_pkg::dp_status_t st,
  input  logic [CW-1:0]         pcnt,
  output rwhpu_pkg::ctrl_cmd_t  cmd,
  output logic [AW-1:0]         pm_raddr,
  output logic [AW-1:0]         hl_addr
);
  import rwhpu_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SS     = 5'd1;
  localparam logic [4:0] S_SSLOAD = 5'd2;
  localparam logic [4:0] S_WORD   = 5'd3;
  localparam logic [4:0] S_EPOCH  = 5'd4;
  localparam logic [4:0] S_DATA   = 5'd5;
  localparam logic [4:0] S_SE     = 5'd6;
  localparam logic [4:0] S_SEDONE = 5'd7;
  localparam logic [4:0] S_FIN    = 5'd8;
  localparam logic [4:0] S_FCOL   = 5'd9;
  localparam logic [4:0] S_FRDM   = 5'd10;
  localparam logic [4:0] S_FWM    = 5'd11;
  localparam logic [4:0] S_FRDH   = 5'd12;
  localparam logic [4:0] S_FCHK   = 5'd13;
  localparam logic [4:0] S_FEMIT  = 5'd14;
  localparam logic [4:0] S_FEMW   = 5'd15;
  localparam logic [4:0] S_FEND   = 5'd16;

  logic [4:0]       state, state_next;
  logic [4:0]       ret, ret_next;
  logic [COL_W-1:0] col, col_next;
  logic [CW-1:0]    i, i_next;
  logic [CW-1:0]    j, j_next;
  logic [CW-1:0]    nh, nh_next;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    col_next   = col;
    i_next     = i;
    j_next     = j;
    nh_next    = nh;
    cmd        = '0;
    cmd.col    = col;
    pm_raddr   = i[AW-1:0];
    hl_addr    = j[AW-1:0];
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_word = 1'b1;
          state_next    = S_SS;
        end
      end
      S_SS: begin
        if (st.ss && st.pend_nz) begin
          col_next = '0; ret_next = S_SSLOAD; state_next = S_FCOL;
        end else begin
          state_next = S_SSLOAD;
        end
      end
      S_SSLOAD: begin
        cmd.ss_apply = st.ss;
        state_next   = S_WORD;
      end
      S_WORD: begin
        if (st.aux) begin
          if (!st.ch_zero) begin
            state_next = S_SE;
          end else if (st.pend_nz) begin
            col_next = '0; ret_next = S_EPOCH; state_next = S_FCOL;
          end else begin
            state_next = S_EPOCH;
          end
        end else if (st.grp_change && st.pend_nz) begin
          col_next = '0; ret_next = S_DATA; state_next = S_FCOL;
        end else begin
          state_next = S_DATA;
        end
      end
      S_EPOCH: begin
        cmd.epoch_apply = 1'b1;
        state_next      = S_SE;
      end
      S_DATA: begin
        cmd.data_apply = 1'b1;
        state_next     = S_SE;
      end
      S_SE: begin
        if (st.se && st.pend_nz) begin
          col_next = '0; ret_next = S_SEDONE; state_next = S_FCOL;
        end else begin
          state_next = S_SEDONE;
        end
      end
      S_SEDONE: begin
        cmd.se_apply = st.se;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!st.fin_stall) state_next = S_IDLE;
      end
      S_FCOL: begin
        i_next     = '0;
        nh_next    = '0;
        state_next = S_FRDM;
      end
      S_FRDM: begin
        if (i == pcnt) begin
          j_next     = '0;
          state_next = S_FEMIT;
        end else begin
          cmd.pm_rd  = 1'b1;
          state_next = S_FWM;
        end
      end
      S_FWM: begin
        if (st.msg_in_col) begin
          j_next     = '0;
          state_next = S_FRDH;
        end else begin
          i_next     = i + 1'b1;
          state_next = S_FRDM;
        end
      end
      S_FRDH: begin
        if (j == nh) begin
          // no earlier hit took it: open a new one
          hl_addr    = nh[AW-1:0];
          cmd.hl_new = 1'b1;
          nh_next    = nh + 1'b1;
          i_next     = i + 1'b1;
          state_next = S_FRDM;
        end else begin
          cmd.hl_rd  = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (st.hit_match) begin
          cmd.hl_merge = 1'b1;
          i_next       = i + 1'b1;
          state_next   = S_FRDM;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_FRDH;
        end
      end
      S_FEMIT: begin
        if (j == nh) begin
          if (col == COL_W'(NUM_COLUMNS - 1)) begin
            state_next = S_FEND;
          end else begin
            col_next   = col + 1'b1;
            state_next = S_FCOL;
          end
        end else begin
          cmd.hl_rd  = 1'b1;
          state_next = S_FEMW;
        end
      end
      S_FEMW: begin
        cmd.push = 1'b1;
        if (!st.push_stall) begin
          j_next     = j + 1'b1;
          state_next = S_FEMIT;
        end
      end
      S_FEND: begin
        cmd.flush_end = 1'b1;
        state_next    = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      col   <= '0;
      i     <= '0;
      j     <= '0;
      nh    <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      col   <= col_next;
      i     <= i_next;
      j     <= j_next;
      nh    <= nh_next;
    end
  end

endmodule

@@ src/readout_word_hit_pairing_unpacker_core.sv @@
// Top level of the readout word unpacker with hit pairing.
// Depends on rwhpu_pkg, rwhpu_in_if, rwhpu_out_if, rwhpu_ctrl, rwhpu_datapath.
//
//  channel | dir | item
//  words   | in  | word, base_time, slice_start, slice_end
//  hits    | out | pad_address, charge_t, charge_r, hit_time, time_offset, dropped, last
//
// A word is taken only when idle, after the last word and its flushes (pause words skip a step).
// Per column a flush reads each buffered message, compares one in the column with each earlier
// hit in turn, opens a new hit if none matches, then emits hits; the hit list is single-port.
// Synchronous reset clears the group state and time base; no clearing pass.
// A stalled hits channel holds the flush at the hit being emitted.
module readout_word_hit_pairing_unpacker_core #(
  parameter int NUM_COLUMNS   = 8,
  parameter int PENDING_DEPTH = 32
) (
  input logic          clk,
  input logic          rst,
  rwhpu_in_if.sink     words,
  rwhpu_out_if.source  hits
);
  import rwhpu_pkg::*;

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  ctrl_cmd_t     cmd;
  dp_status_t    st;
  logic [CW-1:0] pcnt;
  logic [AW-1:0] pm_raddr;
  logic [AW-1:0] hl_addr;
  logic          in_ready;
  logic          out_valid;
  out_item_t     out_data;

  assign words.ready = in_ready;
  assign hits.valid  = out_valid;
  assign hits.data   = out_data;

  rwhpu_ctrl #(
    .NUM_COLUMNS(NUM_COLUMNS), .PENDING_DEPTH(PENDING_DEPTH), .AW(AW), .CW(CW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(words.valid), .in_ready(in_ready),
    .st(st), .pcnt(pcnt), .cmd(cmd), .pm_raddr(pm_raddr), .hl_addr(hl_addr)
  );

  rwhpu_datapath #(
    .NUM_COLUMNS(NUM_COLUMNS), .PENDING_DEPTH(PENDING_DEPTH), .AW(AW), .CW(CW)
  ) u_dp (
    .clk(clk), .rst(rst), .in_data(words.data), .cmd(cmd), .pm_raddr(pm_raddr),
    .hl_addr(hl_addr), .st(st), .pcnt(pcnt), .out_valid(out_valid),
    .out_ready(hits.ready), .out_data(out_data)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench of the readout word unpacker: random and directed words, hits checked in order.
// Depends on rwhpu_pkg, rwhpu_in_if, rwhpu_out_if and readout_word_hit_pairing_unpacker_core.
module testbench;
  import rwhpu_pkg::*;

  localparam int NCOL     = 8;
  localparam int DEPTH    = 32;
  localparam int WDOG_MAX = 20000;

  class hit_scoreboard;
    int unsigned p_ch[DEPTH];
    int unsigned p_tl[DEPTH];
    int unsigned p_amp[DEPTH];
    int unsigned p_cnt;
    int unsigned grp_chip;
    bit grp_open;
    bit grp_drop;
    logic [TB_W-1:0] tbase;
    out_item_t hits_due[$];
    out_item_t step_hits[$];
    bit step_ovf;
    int errors;

    function new();
      p_cnt = 0; grp_chip = 0; grp_open = 0; grp_drop = 0; tbase = '0; errors = 0;
    endfunction

    function void flush_group();
      int unsigned h_tl[DEPTH];
      int unsigned h_t[DEPTH];
      int unsigned h_r[DEPTH];
      int h_off[DEPTH];
      int unsigned nh, lr, lt;
      int d;
      bit used;
      out_item_t o;
      for (int col = 0; col < NCOL; col++) begin
        nh = 0;
        for (int i = 0; i < p_cnt; i++) begin
          if ((p_ch[i] >> 1) != col) continue;
          lr = p_ch[i][0] ? p_amp[i] : 0;
          lt = p_ch[i][0] ? 0 : p_amp[i];
          used = 0;
          for (int j = 0; j < nh; j++) begin
            d = int'(h_tl[j]) - int'(p_tl[i]);
            if (d > -5 && d < 5) begin
              if (lr != 0 && h_r[j] == 0) begin
                h_r[j] = lr; h_off[j] = -d; used = 1; break;
              end else if (lt != 0 && h_t[j] == 0) begin
                h_t[j] = lt; h_off[j] = d; used = 1; break;
              end
            end
          end
          if (!used && nh < DEPTH) begin
            h_tl[nh] = p_tl[i]; h_t[nh] = lt; h_r[nh] = lr; h_off[nh] = 0;
            nh++;
          end
        end
        for (int j = 0; j < nh; j++) begin
          if (step_hits.size() >= MAX_RESULTS) begin
            step_ovf = 1;
          end else begin
            o.pad_address = PAD_W'(grp_chip * NCOL + col);
            o.charge_t    = AMP_W'(h_t[j]);
            o.charge_r    = AMP_W'(h_r[j]);
            o.hit_time    = tbase + TB_W'(h_tl[j]);
            o.time_offset = OFF_W'(h_off[j]);
            o.dropped     = grp_drop;
            o.last        = 1'b0;
            step_hits = {step_hits, o};
          end
        end
      end
      p_cnt = 0; grp_drop = 0; grp_open = 0;
    endfunction

    function void note_word(in_item_t it);
      int unsigned ch, tl, amp, chip;
      out_item_t o;
      ch   = it.word[3:0];
      tl   = it.word[11:5];
      amp  = it.word[25:13];
      chip = it.word[31:26];
      step_hits.delete();
      step_ovf = 0;
      if (it.slice_start) begin
        if (p_cnt != 0) flush_group();
        grp_open = 0;
        tbase = it.base_time;
      end
      if (it.word[4]) begin
        // epoch only on channel 0; other aux words are ignored
        if (ch == 0) begin
          if (p_cnt != 0) flush_group();
          grp_open = 0;
          if (chip == 0) tbase = tbase + EPOCH_STEP;
        end
      end else begin
        if (!grp_open || grp_chip != chip) begin
          if (p_cnt != 0) flush_group();
          grp_chip = chip; grp_open = 1; grp_drop = 0;
        end
        if ((ch >> 1) < NCOL) begin
          if (p_cnt < DEPTH) begin
            p_ch[p_cnt] = ch; p_tl[p_cnt] = tl; p_amp[p_cnt] = amp;
            p_cnt++;
          end else begin
            grp_drop = 1;
          end
        end
      end
      if (it.slice_end) begin
        if (p_cnt != 0) flush_group();
        grp_open = 0; grp_drop = 0;
      end
      if (step_hits.size() > 0) begin
        o = step_hits.pop_back();
        if (step_ovf) o.dropped = 1'b1;
        o.last = 1'b1;
        step_hits = {step_hits, o};
      end
      hits_due = {hits_due, step_hits};
    endfunction

    function void check_hit(out_item_t got);
      out_item_t want;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected hit pad=%0d t=%0d r=%0d time=%h", $time,
                 got.pad_address, got.charge_t, got.charge_r, got.hit_time);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: hit mismatch expected pad=%0d t=%0d r=%0d time=%h off=%0d drop=%b last=%b",
                 $time, want.pad_address, want.charge_t, want.charge_r, want.hit_time,
                 want.time_offset, want.dropped, want.last);
        $display("%0t:              actual pad=%0d t=%0d r=%0d time=%h off=%0d drop=%b last=%b",
                 $time, got.pad_address, got.charge_t, got.charge_r, got.hit_time,
                 got.time_offset, got.dropped, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  rwhpu_in_if  words();
  rwhpu_out_if hits();

  readout_word_hit_pairing_unpacker_core #(.NUM_COLUMNS(NCOL), .PENDING_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .words(words.sink), .hits(hits.source)
  );

  hit_scoreboard sb = new();
  int  n_sent = 0;
  int  burst_left = 0;
  bit  hold_req = 0;
  int  idle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    words.valid = 1'b0;
    words.data  = '0;
    hits.ready  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // receiver: stall pattern switches between random modes, long hold on request
  always @(negedge clk) begin : rx_pattern
    int cyc, mode, hold;
    if (hold_req && hold == 0) hold = 400;
    if (hold > 0) begin
      hits.ready <= 1'b0;
      hold--;
      if (hold == 0) hold_req = 0;
    end else begin
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: hits.ready <= 1'b1;
        1: hits.ready <= ($urandom_range(0, 1) == 1);
        2: hits.ready <= ($urandom_range(0, 3) == 0);
        default: hits.ready <= ((cyc % 7) < 5);
      endcase
    end
    cyc++;
  end

  always @(posedge clk) begin
    if (!rst && hits.valid && hits.ready) sb.check_hit(hits.data);
  end

  always @(posedge clk) begin
    if ((words.valid && words.ready) || (hits.valid && hits.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WDOG_MAX) begin
      $display("%0t: watchdog expired, %0d hits outstanding", $time, sb.hits_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input logic [31:0] w, input logic [TB_W-1:0] bt,
                      input bit ss, input bit se);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      @(negedge clk) words.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    it.word = w; it.base_time = bt; it.slice_start = ss; it.slice_end = se;
    @(negedge clk);
    words.valid <= 1'b1;
    words.data  <= it;
    do @(posedge clk); while (!words.ready);
    sb.note_word(it);
    n_sent++;
  endtask

  function automatic logic [31:0] data_word(int chip, int ch, int tl, int amp);
    return {6'(chip), 13'(amp), 1'($urandom_range(0, 1)), 7'(tl), 1'b0, 4'(ch)};
  endfunction

  function automatic logic [31:0] aux_word(int chip, int ch);
    logic [31:0] w;
    w = $urandom;
    w[31:26] = 6'(chip);
    w[4] = 1'b1;
    w[3:0] = 4'(ch);
    return w;
  endfunction

  function automatic logic [TB_W-1:0] rand_base();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic drain();
    @(negedge clk) words.valid <= 1'b0;
    while (sb.hits_due.size() != 0) @(posedge clk);
  endtask

  task automatic rand_group();
    int chip, n, lab, ch, amp;
    chip = $urandom_range(0, 63);
    n = $urandom_range(1, 12);
    lab = $urandom_range(0, 127);
    for (int i = 0; i < n; i++) begin
      ch  = $urandom_range(0, 15);
      amp = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 8191);
      send(data_word(chip, ch, (lab + $urandom_range(0, 12)) % 128, amp), rand_base(),
           ($urandom_range(0, 15) == 0), (i == n - 1) && ($urandom_range(0, 3) == 0));
    end
    case ($urandom_range(0, 3))
      0: send(aux_word($urandom_range(0, 1) ? 0 : $urandom_range(0, 63), 0), rand_base(), 0, 0);
      1: send(aux_word(chip, $urandom_range(1, 15)), rand_base(), 0, 0);
      default: ;
    endcase
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // pairing: R merge, out-of-window label, epoch advance
    send(data_word(0, 0, 10, 8191), '0, 0, 0);
    send(data_word(0, 1, 12, 1), '0, 0, 0);
    send(data_word(0, 0, 3, 77), '0, 0, 0);
    send(data_word(0, 14, 127, 8191), '0, 0, 0);
    send(data_word(0, 15, 123, 4000), '0, 0, 0);
    send(aux_word(0, 0), '0, 0, 0);
    // time wrap at maximum base, then chip change flush
    send(data_word(63, 2, 127, 5), '1, 1, 0);
    send(data_word(63, 3, 127, 0), '0, 0, 0);
    send(data_word(62, 4, 0, 9), '0, 0, 0);
    // zero amplitude, pause ignored, epoch on nonzero chip
    send(data_word(62, 5, 1, 0), '0, 0, 0);
    send(aux_word(62, 7), '0, 0, 0);
    send(aux_word(62, 0), '0, 0, 1);
    // slice start flushes pending group with old time base
    send(data_word(9, 6, 50, 100), '0, 0, 0);
    send(data_word(9, 7, 46, 200), 48'h1234_5678_9abc, 1, 1);
    drain();

    // full buffer with dropped words, then more hits than one step can emit
    for (int i = 0; i < DEPTH + 2; i++) send(data_word(5, i % 16, i * 3, 0), '0, 0, 0);
    send(data_word(5, 0, 0, 1), '0, 1, 1);
    drain();

    // long receiver hold while words keep coming
    hold_req = 1;
    for (int i = 0; i < 30; i++) send(data_word(i % 4, $urandom_range(0, 15),
                                             $urandom_range(0, 127), $urandom), '0, 0, 0);
    drain();

    while (n_sent < 300) begin
      if ($urandom_range(0, 6) == 0) begin
        send($urandom, rand_base(), $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        rand_group();
      end
      if ($urandom_range(0, 40) == 0) drain();
    end
    send(aux_word(0, 0), '0, 0, 1);
    drain();
    repeat (1500) @(posedge clk);
    if (sb.errors == 0 && sb.hits_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
